>>> rtl/bsi_pkg.sv
// shared types and constants of the bounded stack with bottom increment
package bsi_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 11;
	localparam int COUNT_W   = 11;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH = 2'd0,
		FUNC_POP  = 2'd1,
		FUNC_INC  = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_held;
	} sts_t;

endpackage

>>> rtl/bsi_ram.sv
// generic simple dual-port ram with registered read
module bsi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/bsi_ctrl.sv
// controller state machine: a read step then a write step per item
module bsi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bsi_pkg::sts_t  sts,
	output bsi_pkg::cmd_t  cmd
);

	bsi_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsi_pkg::ST_IDLE: begin
				if (in_valid) state_d = bsi_pkg::ST_EXEC;
			end
			bsi_pkg::ST_EXEC: begin
				if (!sts.out_held) state_d = bsi_pkg::ST_IDLE;
			end
			default: state_d = bsi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			bsi_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			bsi_pkg::ST_EXEC: begin
				// wait while the previous result is still unclaimed
				cmd.commit = !sts.out_held;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/bsi_dp.sv
// datapath: occupancy, capacity, lazy increment bookkeeping and result register
module bsi_dp #(
	parameter int DEPTH = bsi_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsi_pkg::cmd_t                 cmd,
	output bsi_pkg::sts_t                 sts,
	input  logic                          cfg_wr_en,
	input  logic [bsi_pkg::CAP_W-1:0]     cfg_wr_data,
	input  logic [bsi_pkg::FUNC_W-1:0]    func,
	input  logic signed [bsi_pkg::DATA_W-1:0] push_value,
	input  logic [bsi_pkg::COUNT_W-1:0]   bottom_count,
	input  logic signed [bsi_pkg::DATA_W-1:0] add_amount,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [bsi_pkg::DATA_W-1:0] pop_value,
	output logic [bsi_pkg::STATUS_W-1:0]  status
);

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > bsi_pkg::COUNT_W) ? CNT_W : bsi_pkg::COUNT_W;
	localparam int DW     = bsi_pkg::DATA_W;

	logic [CNT_W-1:0]          occ_q;
	logic [bsi_pkg::CAP_W-1:0] capacity_q;
	logic [DW-1:0]             top_inc_q;
	logic                      out_valid_q;
	logic [DW-1:0]             pop_value_q;
	bsi_pkg::status_t          status_q;

	bsi_pkg::func_t            op_s1;
	logic [DW-1:0]             push_value_s1;
	logic [DW-1:0]             add_amount_s1;
	logic                      push_ok_s1;
	logic                      pop_ok_s1;
	logic                      below_s1;
	logic                      inc_top_s1;
	logic                      inc_mem_s1;
	logic [ADDR_W-1:0]         inc_addr_s1;

	logic [CMP_W-1:0]          occ_ext;
	logic [CMP_W-1:0]          cap_ext;
	logic [CMP_W-1:0]          bc_ext;
	logic [CNT_W-1:0]          n_eff;
	logic                      push_ok;
	logic [CNT_W-1:0]          occ_m1;
	logic [CNT_W-1:0]          occ_m2;
	logic [CNT_W-1:0]          n_m1;
	bsi_pkg::func_t            op_in;
	logic [ADDR_W-1:0]         inc_rd_addr;

	logic                      st_wr_en;
	logic [DW-1:0]             st_rd_data;
	logic                      inc_wr_en;
	logic [DW-1:0]             inc_wr_data;
	logic [DW-1:0]             inc_rd_data;
	logic [DW-1:0]             popped;
	logic [DW-1:0]             res_value;
	bsi_pkg::status_t          res_status;

	assign op_in   = bsi_pkg::func_t'(func);
	assign occ_ext = CMP_W'(occ_q);
	assign cap_ext = CMP_W'(capacity_q);
	assign bc_ext  = CMP_W'(bottom_count);
	assign occ_m1  = occ_q - CNT_W'(1);
	assign occ_m2  = occ_q - CNT_W'(2);
	// occupancy never exceeds depth, so this also saturates the count to depth
	assign n_eff   = (bc_ext < occ_ext) ? CNT_W'(bottom_count) : occ_q;
	assign n_m1    = n_eff - CNT_W'(1);
	assign push_ok = (occ_ext < cap_ext) && (occ_q < CNT_W'(DEPTH));

	always_comb begin
		unique case (op_in)
			bsi_pkg::FUNC_PUSH: inc_rd_addr = occ_m1[ADDR_W-1:0];
			bsi_pkg::FUNC_POP:  inc_rd_addr = occ_m2[ADDR_W-1:0];
			bsi_pkg::FUNC_INC:  inc_rd_addr = n_m1[ADDR_W-1:0];
			default:            inc_rd_addr = occ_m1[ADDR_W-1:0];
		endcase
	end

	// capture stage
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1         <= op_in;
			push_value_s1 <= push_value;
			add_amount_s1 <= add_amount;
			push_ok_s1    <= (op_in == bsi_pkg::FUNC_PUSH) && push_ok;
			pop_ok_s1     <= occ_q != '0;
			below_s1      <= occ_q > CNT_W'(1);
			inc_top_s1    <= (op_in == bsi_pkg::FUNC_INC) && (n_eff != '0) && (n_eff == occ_q);
			inc_mem_s1    <= (op_in == bsi_pkg::FUNC_INC) && (n_eff != '0) && (n_eff != occ_q);
			inc_addr_s1   <= inc_rd_addr;
		end
	end

	assign popped = st_rd_data + top_inc_q;

	// commit stage memory writes
	always_comb begin
		st_wr_en    = cmd.commit && push_ok_s1;
		inc_wr_en   = 1'b0;
		inc_wr_data = top_inc_q;
		if (cmd.commit && push_ok_s1 && pop_ok_s1) begin
			// old top moves down: its pending add goes to the store
			inc_wr_en   = 1'b1;
			inc_wr_data = top_inc_q;
		end else if (cmd.commit && inc_mem_s1) begin
			inc_wr_en   = 1'b1;
			inc_wr_data = inc_rd_data + add_amount_s1;
		end
	end

	bsi_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_entry_ram (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (occ_q[ADDR_W-1:0]),
		.wr_data (push_value_s1),
		.rd_en   (cmd.capture),
		.rd_addr (occ_m1[ADDR_W-1:0]),
		.rd_data (st_rd_data)
	);

	bsi_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_pend_ram (
		.clk     (clk),
		.wr_en   (inc_wr_en),
		.wr_addr (inc_addr_s1),
		.wr_data (inc_wr_data),
		.rd_en   (cmd.capture),
		.rd_addr (inc_rd_addr),
		.rd_data (inc_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			capacity_q  <= bsi_pkg::CAP_RESET;
			top_inc_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) capacity_q <= cfg_wr_data;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				unique case (op_s1)
					bsi_pkg::FUNC_PUSH: begin
						if (push_ok_s1) begin
							occ_q     <= occ_q + CNT_W'(1);
							top_inc_q <= '0;
						end
					end
					bsi_pkg::FUNC_POP: begin
						if (pop_ok_s1) begin
							occ_q     <= occ_m1;
							top_inc_q <= below_s1 ? (inc_rd_data + top_inc_q) : '0;
						end
					end
					bsi_pkg::FUNC_INC: begin
						if (inc_top_s1) top_inc_q <= top_inc_q + add_amount_s1;
					end
					default: ;
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result of the item being committed
	always_comb begin
		res_value  = '0;
		res_status = bsi_pkg::STATUS_DONE;
		unique case (op_s1)
			bsi_pkg::FUNC_PUSH: begin
				if (!push_ok_s1) res_status = bsi_pkg::STATUS_FULL;
			end
			bsi_pkg::FUNC_POP: begin
				if (pop_ok_s1) begin
					res_value = popped;
				end else begin
					res_value  = '1;
					res_status = bsi_pkg::STATUS_EMPTY;
				end
			end
			default: ;
		endcase
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			pop_value_q <= res_value;
			status_q    <= res_status;
		end
	end

	assign sts.out_held = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign pop_value    = pop_value_q;
	assign status       = status_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == bsi_pkg::STATUS_EMPTY) |-> pop_value_q == '1)
		else $error("empty pop must answer -1");

	a_full_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == bsi_pkg::STATUS_FULL) |-> pop_value_q == '0)
		else $error("full push must answer zero");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && push_ok_s1 |=> occ_q == $past(occ_q) + CNT_W'(1))
		else $error("push did not grow occupancy");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && !out_ready))
		else $error("result overwritten before taken");

endmodule

>>> rtl/bounded_stack_with_bottom_increment_unit.sv
// top level of the bounded stack with bottom increment
//
// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------------
// in       | in_valid / in_ready       | func, push_value, bottom_count, add_amount
// out      | out_valid / out_ready     | pop_value, status
// cfg      | cfg_wr_en (no wait)       | cfg_wr_data (capacity)
//
// every item takes a read step on both rams, then a write step
// that updates at most one entry of each ram and loads the result register
// the single read-modify-write of the pending-increment ram needs both steps
// an unclaimed result holds the write step until out_ready; the next item is
// still accepted while a result waits in the output register
// reset empties the stack and sets capacity to 1024; the rams are not cleared
module bounded_stack_with_bottom_increment_unit #(
	parameter int DEPTH = bsi_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [bsi_pkg::CAP_W-1:0]         cfg_wr_data,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bsi_pkg::FUNC_W-1:0]        func,
	input  logic signed [bsi_pkg::DATA_W-1:0] push_value,
	input  logic [bsi_pkg::COUNT_W-1:0]       bottom_count,
	input  logic signed [bsi_pkg::DATA_W-1:0] add_amount,
	// result items
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [bsi_pkg::DATA_W-1:0] pop_value,
	output logic [bsi_pkg::STATUS_W-1:0]      status
);

	// increments are kept lazily: the pending ram holds, per entry, an amount
	// owed to it and every entry below; the top entry's amount sits in a register
	bsi_pkg::cmd_t cmd;
	bsi_pkg::sts_t sts;

	bsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsi_dp #(.DEPTH(DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.func         (func),
		.push_value   (push_value),
		.bottom_count (bottom_count),
		.add_amount   (add_amount),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pop_value    (pop_value),
		.status       (status)
	);

endmodule
